/* sv/rfbt_pkg.sv */
package rfbt_pkg;

   // Default ring length in words.
   localparam int RING_WORDS_DEFAULT = 65536;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;

   // Frame stride limits and related constants.
   localparam logic [10:0] STRIDE_MIN = 11'd2;
   localparam logic [10:0] STRIDE_MAX = 11'd1024;
   localparam logic [10:0] STRIDE_RESET = 11'd2;
   localparam logic [14:0] COUNT_MAX = 15'h7FFF;
   localparam logic [31:0] BATTERY_MASK = 32'h4000_0000;

   // Operation codes of an input word.
   localparam logic OP_STORE = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   // Register indexes on the configuration port.
   localparam logic REG_SYNC_WORD = 1'b0;
   localparam logic REG_FRAME_STRIDE = 1'b1;

   typedef struct packed {
      logic        op;
      logic [15:0] word_address;
      logic [31:0] word_data;
      logic [15:0] write_position;
   } req_word_type;

   typedef struct packed {
      logic        new_block;
      logic [15:0] start_index;
      logic [14:0] frame_count;
      logic [14:0] sync_count;
      logic        battery_low;
      logic [10:0] block_stride;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] sync_word;
      logic [10:0] frame_stride;
   } cfg_type;

   // Clamp the programmed stride into the supported range.
   function automatic logic [10:0] eff_stride(input logic [10:0] stride);
      logic [10:0] result;
      result = stride;
      if (stride < STRIDE_MIN) begin
         result = STRIDE_MIN;
      end else if (stride > STRIDE_MAX) begin
         result = STRIDE_MAX;
      end
      return result;
   endfunction

endpackage

/* sv/rfbt_front.sv */
module rfbt_front
   import rfbt_pkg::*;
#(
   parameter int RING_WORDS = RING_WORDS_DEFAULT,
   parameter int AW = $clog2(RING_WORDS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_word_type      req_word,
   output logic              push_valid,
   input  logic              push_full,
   output logic [AW+32:0]    push_entry
);

   // Reciprocal of the ring length, scaled by 2^32.
   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / RING_WORDS);
   localparam logic [AW:0] RING_N = (AW+1)'(RING_WORDS);

   logic        stage_valid_ff, stage_valid_in;
   logic        op_ff;
   logic [15:0] pos_ff;
   logic [31:0] data_ff;
   logic [16:0] quot_ff;
   logic [15:0] sel_pos;
   logic [48:0] quot_prod;
   logic [37:0] quot_times_n;
   logic [16:0] rem_raw;
   logic [AW:0] rem_ext;
   logic [AW:0] rem_fix;
   logic        accept;

   // The stage stalls only when it holds a word that the queue cannot take.
   assign req_stall = stage_valid_ff & push_full;
   assign accept = req_valid & ~req_stall;
   assign push_valid = stage_valid_ff;

   // Pick the position that needs reducing into the ring and estimate the quotient.
   assign sel_pos = (req_word.op == OP_REPORT) ? req_word.write_position
                                               : req_word.word_address;
   assign quot_prod = 49'(sel_pos) * 49'(RECIP);

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_valid_ff && !push_full) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_word.op;
         pos_ff <= sel_pos;
         data_ff <= req_word.word_data;
         quot_ff <= quot_prod[48:32];
      end
   end

   // The estimate is at most one low, so one compare and subtract finishes the modulo.
   assign quot_times_n = 38'(quot_ff) * 38'(RING_N);
   assign rem_raw = 17'(pos_ff) - quot_times_n[16:0];
   assign rem_ext = (AW+1)'(rem_raw);

   always_comb begin
      rem_fix = rem_ext;
      if (rem_ext >= RING_N) begin
         rem_fix = rem_ext - RING_N;
      end
   end

   assign push_entry = {op_ff, rem_fix[AW-1:0], data_ff};

endmodule

/* sv/rfbt_queue.sv */
module rfbt_queue
   import rfbt_pkg::*;
#(
   parameter int WIDTH = 49
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_full,
   input  logic [WIDTH-1:0] push_entry,
   output logic             pop_valid,
   input  logic             pop_take,
   output logic [WIDTH-1:0] pop_entry
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign push_full = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign do_push = push_valid & ~push_full;
   assign do_pop = pop_take & pop_valid;
   assign pop_entry = entry_ff[rd_ptr_ff];

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* sv/rfbt_back.sv */
module rfbt_back
   import rfbt_pkg::*;
#(
   parameter int RING_WORDS = RING_WORDS_DEFAULT,
   parameter int AW = $clog2(RING_WORDS)
) (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           pop_valid,
   output logic           pop_take,
   input  logic [AW+32:0] pop_entry,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_word_type   rsp_word
);

   localparam logic [AW:0] RING_N = (AW+1)'(RING_WORDS);
   localparam logic [AW-1:0] LAST_IDX = AW'(RING_WORDS - 1);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_CALC = 6'b000010,
      ST_RD0  = 6'b000100,
      ST_RD1  = 6'b001000,
      ST_CHK  = 6'b010000,
      ST_RESP = 6'b100000
   } state_type;

   state_type    state_ff, state_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] last_pos_ff, last_pos_in;
   logic [AW-1:0] fs_ff, fs_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW:0]   rem_ff, rem_in;
   logic [10:0]   stride_ff, stride_in;
   logic [14:0]   nfr_ff, nfr_in;
   logic [14:0]   nsync_ff, nsync_in;
   logic          batt_ff, batt_in;
   logic          blk_ff, blk_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_ff, rsp_in;

   logic [31:0]   ring_mem_ff [RING_WORDS];
   logic [31:0]   rd_ff;
   logic [AW-1:0] raddr;
   logic          mem_we;

   logic          pop_op;
   logic [AW-1:0] pop_addr;
   logic [31:0]   pop_data;
   logic [AW:0]   span;
   logic [AW:0]   diff;
   logic [AW:0]   stride_ext;
   logic [AW:0]   rem_next;
   logic [AW:0]   idx_sum;
   logic [AW-1:0] idx_next;
   logic [AW-1:0] idx_plus1;
   logic          slot_free;

   assign {pop_op, pop_addr, pop_data} = pop_entry;
   assign pop_take = (state_ff == ST_IDLE);
   assign mem_we = (state_ff == ST_IDLE) && pop_valid && (pop_op == OP_STORE);
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

   // Words between the frame start and the writer, one wrap allowed.
   assign diff = {1'b0, pos_ff} - {1'b0, fs_ff};
   assign span = (pos_ff > fs_ff) ? diff : diff + RING_N;
   assign stride_ext = (AW+1)'(stride_ff);

   // Step to the next frame, wrapping the index into the ring.
   assign rem_next = rem_ff - stride_ext;
   assign idx_sum = {1'b0, idx_ff} + stride_ext;
   assign idx_next = (idx_sum >= RING_N) ? AW'(idx_sum - RING_N) : idx_sum[AW-1:0];
   assign idx_plus1 = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign raddr = (state_ff == ST_RD1) ? idx_plus1 : idx_ff;

   // Ring memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem_ff[pop_addr] <= pop_data;
      end
      rd_ff <= ring_mem_ff[raddr];
   end

   // Sequencer for reports: check for a block, then scan frame by frame.
   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      last_pos_in = last_pos_ff;
      fs_in = fs_ff;
      idx_in = idx_ff;
      rem_in = rem_ff;
      stride_in = stride_ff;
      nfr_in = nfr_ff;
      nsync_in = nsync_ff;
      batt_in = batt_ff;
      blk_in = blk_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid && pop_op == OP_REPORT) begin
               pos_in = pop_addr;
               stride_in = eff_stride(cfg.frame_stride);
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            nfr_in = '0;
            nsync_in = '0;
            batt_in = 1'b0;
            idx_in = fs_ff;
            rem_in = span;
            if (pos_ff == last_pos_ff || span < stride_ext) begin
               blk_in = 1'b0;
               state_in = ST_RESP;
            end else begin
               blk_in = 1'b1;
               state_in = ST_RD0;
            end
         end
         ST_RD0: begin
            state_in = ST_RD1;
         end
         ST_RD1: begin
            if (rd_ff == cfg.sync_word && nsync_ff != COUNT_MAX) begin
               nsync_in = nsync_ff + 1'b1;
            end
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if ((rd_ff & BATTERY_MASK) != '0) begin
               batt_in = 1'b1;
            end
            if (nfr_ff != COUNT_MAX) begin
               nfr_in = nfr_ff + 1'b1;
            end
            rem_in = rem_next;
            idx_in = idx_next;
            state_in = (rem_next >= stride_ext) ? ST_RD0 : ST_RESP;
         end
         ST_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.new_block = blk_ff;
               rsp_in.start_index = blk_ff ? 16'(fs_ff) : '0;
               rsp_in.frame_count = blk_ff ? nfr_ff : '0;
               rsp_in.sync_count = blk_ff ? nsync_ff : '0;
               rsp_in.battery_low = blk_ff & batt_ff;
               rsp_in.block_stride = stride_ff;
               if (blk_ff) begin
                  fs_in = idx_ff;
                  last_pos_in = pos_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_pos_ff <= '0;
         fs_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_pos_ff <= last_pos_in;
         fs_ff <= fs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      rem_ff <= rem_in;
      stride_ff <= stride_in;
      nfr_ff <= nfr_in;
      nsync_ff <= nsync_in;
      batt_ff <= batt_in;
      blk_ff <= blk_in;
      rsp_ff <= rsp_in;
   end

   // A word without a block carries no counts and no start.
   a_no_block_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.new_block |->
         rsp_ff.frame_count == '0 && rsp_ff.sync_count == '0 &&
         rsp_ff.start_index == '0 && !rsp_ff.battery_low)
      else $error("no-block word carries nonzero fields");

   // A block always holds at least one frame, and no more sync hits than frames.
   a_block_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.new_block |->
         rsp_ff.frame_count != '0 && rsp_ff.sync_count <= rsp_ff.frame_count)
      else $error("block counts inconsistent");

   // The scan index and the frame start stay inside the ring.
   a_idx_in_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD0 || state_ff == ST_RD1 || state_ff == ST_CHK) |->
         {1'b0, idx_ff} < RING_N && {1'b0, fs_ff} < RING_N)
      else $error("ring index out of range");

   // A stalled result word holds until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result word changed while stalled");

   // Entering the scan means at least one whole frame remains.
   a_scan_has_frame: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD0 |-> rem_ff >= stride_ext)
      else $error("scan started without a whole frame");

endmodule

/* sv/ring_frame_block_tracker.sv */
// Store words are accepted one per cycle while the queue has room and reach the ring
// through the front stage register and the queue. A position report takes the same
// path, then the back part reads the ring memory twice and checks once per new frame.
// Reset is synchronous: it resets the configuration registers, the frame start and last
// position, the front stage and the queue; the ring memory is not cleared and needs no
// clearing pass.
module ring_frame_block_tracker
   import rfbt_pkg::*;
#(
   parameter int RING_WORDS = RING_WORDS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int AW = $clog2(RING_WORDS);
   localparam int EW = AW + 33;

   logic [31:0]   sync_word_ff;
   logic [10:0]   frame_stride_ff;
   cfg_type       cfg;
   logic          cfg_write;
   logic          push_valid;
   logic          push_full;
   logic [EW-1:0] push_entry;
   logic          pop_valid;
   logic          pop_take;
   logic [EW-1:0] pop_entry;

   // Configuration registers.
   assign pready = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff <= '0;
         frame_stride_ff <= STRIDE_RESET;
      end else if (cfg_write) begin
         if (paddr[2] == REG_SYNC_WORD) begin
            sync_word_ff <= pwdata;
         end else begin
            frame_stride_ff <= pwdata[10:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_FRAME_STRIDE) ? {21'b0, frame_stride_ff} : sync_word_ff;
   assign cfg.sync_word = sync_word_ff;
   assign cfg.frame_stride = frame_stride_ff;

   rfbt_front #(
      .RING_WORDS(RING_WORDS),
      .AW(AW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .push_valid(push_valid),
      .push_full(push_full),
      .push_entry(push_entry)
   );

   rfbt_queue #(
      .WIDTH(EW)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_full(push_full),
      .push_entry(push_entry),
      .pop_valid(pop_valid),
      .pop_take(pop_take),
      .pop_entry(pop_entry)
   );

   rfbt_back #(
      .RING_WORDS(RING_WORDS),
      .AW(AW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .pop_valid(pop_valid),
      .pop_take(pop_take),
      .pop_entry(pop_entry),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

endmodule
